// ===== src/ir_pulse_width_decoder_learn_match_top_macros.svh =====
// Assertion macros for the IR pulse-width decoder.
// Included by modules that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef IR_PULSE_WIDTH_DECODER_LEARN_MATCH_TOP_MACROS_SVH
`define IR_PULSE_WIDTH_DECODER_LEARN_MATCH_TOP_MACROS_SVH

// Property checked on every aclk edge outside reset.
`define IRPW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Expression that must hold on every aclk edge outside reset.
`define IRPW_ASSERT_ALWAYS(label, expr, msg) \
    `IRPW_ASSERT(label, 1'b1 |-> (expr), msg)

`endif

// ===== src/irpw_pkg.sv =====
// Shared types and constants for the IR pulse-width decoder.
// No dependencies; imported by the top level.
package irpw_pkg;

    localparam int SHIFT_BITS  = 32;
    localparam int VOTE_WINDOW = 10;
    localparam int CODE_W      = SHIFT_BITS - 1;
    localparam int OUT_W       = 31;
    localparam int CNT_W       = 10;
    localparam int EDGE_W      = 8;
    localparam int VOTE_CNT_W  = $clog2(VOTE_WINDOW + 1);
    localparam int THR_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CNT_W-1:0] TICK_CLAMP_ABOVE = CNT_W'(1000);
    localparam logic [CNT_W-1:0] TICK_CLAMP_TO    = CNT_W'(999);
    localparam logic [CNT_W-1:0] IDLE_MAX         = '1;
    localparam logic [EDGE_W-1:0] EDGE_MAX        = '1;

    localparam logic [CNT_W-1:0] BIT_MIN_RST   = CNT_W'(14);
    localparam logic [CNT_W-1:0] BIT_MAX_RST   = CNT_W'(23);
    localparam logic [CNT_W-1:0] TIMEOUT_RST   = CNT_W'(200);
    localparam logic [THR_W-1:0] VOTE_THR_RST  = THR_W'(9);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_MIN  = 2'd0,
        REG_BIT_MAX  = 2'd1,
        REG_TIMEOUT  = 2'd2,
        REG_VOTE_THR = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_EDGE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_MATCH    = 2'd1,
        EV_MISMATCH = 2'd2,
        EV_LEARNED  = 2'd3
    } event_t;

    typedef struct packed {
        logic cmd;
        logic button_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [OUT_W-1:0] code;
        logic [OUT_W-1:0] learned_code;
    } out_item_t;

endpackage

// ===== src/ir_pulse_width_decoder_learn_match_top.sv =====
// IR pulse-width decoder with learn and match: top level.
// Depends on irpw_pkg and ir_pulse_width_decoder_learn_match_top_macros.svh.
//
// Every input transaction (a timer tick with a button sample, or an IR edge)
// yields exactly one result transaction. The state update and the result are
// computed combinationally from the current state and the incoming item, and the
// result lands in an output register; one item per cycle is taken while the
// output side keeps up, and a single held result stalls the input only while
// it waits. Configuration is written through cfg_wr_en/cfg_index/cfg_wdata
// and takes effect on the next transaction.
`include "ir_pulse_width_decoder_learn_match_top_macros.svh"

module ir_pulse_width_decoder_learn_match_top
    import irpw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    logic [CNT_W-1:0]      bit_min_reg, bit_max_reg, timeout_reg;
    logic [THR_W-1:0]      vote_thr_reg;

    logic [EDGE_W-1:0]     edge_cnt_reg, edge_cnt_next;
    logic [CNT_W-1:0]      tick_cnt_reg, tick_cnt_next;
    logic [CNT_W-1:0]      idle_cnt_reg, idle_cnt_next;
    logic                  frame_active_reg, frame_active_next;
    logic [SHIFT_BITS-1:0] shift_reg, shift_next;
    logic [CODE_W-1:0]     ref_code_reg, ref_code_next;
    logic                  armed_reg, armed_next;
    logic [VOTE_WINDOW-1:0] hist_reg, hist_next;

    logic                  out_valid_reg;
    out_item_t             out_data_reg, out_data_next;

    logic                  accept;
    logic [VOTE_CNT_W-1:0] vote_cnt;
    logic                  vote_ok;
    logic [CNT_W-1:0]      tick_inc, idle_inc;
    logic                  timeout_hit;
    logic [CODE_W-1:0]     frame_code;
    logic                  bit_one;
    logic [SHIFT_BITS-1:0] shift_base;
    event_t                ev;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        vote_cnt = '0;
        for (int i = 0; i < VOTE_WINDOW; i++) begin
            vote_cnt = vote_cnt + VOTE_CNT_W'(hist_next[i]);
        end
    end

    always_comb begin
        hist_next         = hist_reg;
        armed_next        = armed_reg;
        edge_cnt_next     = edge_cnt_reg;
        tick_cnt_next     = tick_cnt_reg;
        idle_cnt_next     = idle_cnt_reg;
        frame_active_next = frame_active_reg;
        shift_next        = shift_reg;
        ref_code_next     = ref_code_reg;
        ev                = EV_NONE;

        vote_ok     = 1'b0;
        tick_inc    = tick_cnt_reg + CNT_W'(1);
        idle_inc    = (idle_cnt_reg == IDLE_MAX) ? idle_cnt_reg : idle_cnt_reg + CNT_W'(1);
        timeout_hit = (idle_inc >= timeout_reg);
        frame_code  = shift_reg[SHIFT_BITS-1:1];
        bit_one     = (tick_cnt_reg >= bit_min_reg) && (tick_cnt_reg <= bit_max_reg);
        shift_base  = (edge_cnt_reg == '0) ? '0 : shift_reg;

        if (s_data.cmd == CMD_TICK) begin
            hist_next = VOTE_WINDOW'({hist_reg, s_data.button_level});
            vote_ok   = ({1'b0, vote_cnt} >= (VOTE_CNT_W + 1)'(vote_thr_reg));
            if (vote_ok) begin
                armed_next = 1'b1;
            end
            if (frame_active_reg) begin
                tick_cnt_next = (tick_inc > TICK_CLAMP_ABOVE) ? TICK_CLAMP_TO : tick_inc;
                idle_cnt_next = idle_inc;
                if (timeout_hit) begin
                    frame_active_next = 1'b0;
                    edge_cnt_next     = '0;
                    if (frame_code != '0) begin
                        if (armed_next) begin
                            armed_next    = 1'b0;
                            ref_code_next = frame_code;
                            ev            = EV_LEARNED;
                        end else if (frame_code == ref_code_reg) begin
                            ev = EV_MATCH;
                        end else begin
                            ev = EV_MISMATCH;
                        end
                    end
                end
            end
        end else begin
            shift_next = shift_base;
            if (!edge_cnt_reg[0]) begin
                shift_next = {shift_base[SHIFT_BITS-2:1], shift_base[0] | bit_one, 1'b0};
            end
            edge_cnt_next     = (edge_cnt_reg == EDGE_MAX) ? EDGE_MAX - EDGE_W'(1)
                                                            : edge_cnt_reg + EDGE_W'(1);
            tick_cnt_next     = '0;
            idle_cnt_next     = '0;
            frame_active_next = 1'b1;
        end

        out_data_next.event_res    = ev;
        out_data_next.code         = (ev != EV_NONE) ? OUT_W'(frame_code) : '0;
        out_data_next.learned_code = OUT_W'(ref_code_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_min_reg  <= BIT_MIN_RST;
            bit_max_reg  <= BIT_MAX_RST;
            timeout_reg  <= TIMEOUT_RST;
            vote_thr_reg <= VOTE_THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_BIT_MIN:  bit_min_reg  <= cfg_wdata;
                REG_BIT_MAX:  bit_max_reg  <= cfg_wdata;
                REG_TIMEOUT:  timeout_reg  <= cfg_wdata;
                REG_VOTE_THR: vote_thr_reg <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_cnt_reg     <= '0;
            tick_cnt_reg     <= '0;
            idle_cnt_reg     <= '0;
            frame_active_reg <= 1'b0;
            shift_reg        <= '0;
            ref_code_reg     <= '0;
            armed_reg        <= 1'b0;
            hist_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                edge_cnt_reg     <= edge_cnt_next;
                tick_cnt_reg     <= tick_cnt_next;
                idle_cnt_reg     <= idle_cnt_next;
                frame_active_reg <= frame_active_next;
                shift_reg        <= shift_next;
                ref_code_reg     <= ref_code_next;
                armed_reg        <= armed_next;
                hist_reg         <= hist_next;
                out_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    `IRPW_ASSERT_ALWAYS(a_tick_clamped, tick_cnt_reg <= TICK_CLAMP_ABOVE, "tick count above clamp")
    `IRPW_ASSERT(a_edge_opens_frame, accept && s_data.cmd == CMD_EDGE |=> frame_active_reg, "edge did not open frame")
    `IRPW_ASSERT(a_event_has_code, m_valid && m_data.event_res != EV_NONE |-> m_data.code != '0, "event with zero code")
    `IRPW_ASSERT(a_learn_stores, m_valid && m_data.event_res == EV_LEARNED |-> m_data.learned_code == m_data.code, "learned code not stored")
    `IRPW_ASSERT(a_match_equal, m_valid && m_data.event_res == EV_MATCH |-> m_data.learned_code == m_data.code, "match with differing code")

endmodule

// ===== verif/irpw_decode_check.sv =====
`timescale 1ns / 1ps
// Checker for the IR pulse-width decoder: watches both channels and the register port.
// Predicts every result from its own decoder model and compares field by field. Uses irpw_pkg.
module irpw_decode_check
    import irpw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    output int                    fail_count,
    output int                    decodes_pending,
    output int                    results_seen,
    output int                    frame_events
);

    logic [CNT_W-1:0]       win_lo;
    logic [CNT_W-1:0]       win_hi;
    logic [CNT_W-1:0]       idle_limit;
    logic [THR_W-1:0]       vote_thr;

    logic [EDGE_W-1:0]      edge_cnt;
    logic [CNT_W-1:0]       tick_cnt;
    logic [CNT_W-1:0]       idle_cnt;
    logic                   in_frame;
    logic [SHIFT_BITS-1:0]  shift_reg;
    logic [SHIFT_BITS-1:0]  ref_code;
    logic                   armed;
    logic [VOTE_WINDOW-1:0] btn_hist;

    out_item_t pending_decodes[$];

    function automatic out_item_t decode_step(in_item_t item);
        out_item_t             r;
        event_t                ev;
        logic [SHIFT_BITS-1:0] fcode;
        int                    ones;
        ev    = EV_NONE;
        fcode = '0;
        r     = '0;
        if (item.cmd == CMD_TICK) begin
            btn_hist = {btn_hist[VOTE_WINDOW-2:0], item.button_level};
            ones = 0;
            for (int i = 0; i < VOTE_WINDOW; i++) ones += int'(btn_hist[i]);
            if (ones >= int'(vote_thr)) armed = 1'b1;
            if (in_frame) begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt > TICK_CLAMP_ABOVE) tick_cnt = TICK_CLAMP_TO;
                if (idle_cnt < IDLE_MAX) idle_cnt = idle_cnt + 1'b1;
                if (idle_cnt >= idle_limit) begin
                    in_frame = 1'b0;
                    edge_cnt = '0;
                    fcode    = shift_reg >> 1;
                    if (fcode != '0) begin
                        if (armed) begin
                            armed    = 1'b0;
                            ref_code = fcode;
                            ev       = EV_LEARNED;
                        end else if (fcode == ref_code) begin
                            ev = EV_MATCH;
                        end else begin
                            ev = EV_MISMATCH;
                        end
                    end
                end
            end
        end else begin
            if (edge_cnt == '0) shift_reg = '0;
            if (!edge_cnt[0]) begin
                shift_reg = (shift_reg + SHIFT_BITS'(tick_cnt >= win_lo && tick_cnt <= win_hi))
                            << 1;
            end
            edge_cnt = (edge_cnt == EDGE_MAX) ? EDGE_MAX - 1'b1 : edge_cnt + 1'b1;
            tick_cnt = '0;
            idle_cnt = '0;
            in_frame = 1'b1;
        end
        r.event_res    = ev;
        r.code         = (ev != EV_NONE) ? fcode[OUT_W-1:0] : '0;
        r.learned_code = ref_code[OUT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t pred;
        if (!aresetn) begin
            win_lo     = BIT_MIN_RST;
            win_hi     = BIT_MAX_RST;
            idle_limit = TIMEOUT_RST;
            vote_thr   = VOTE_THR_RST;
            edge_cnt   = '0;
            tick_cnt   = '0;
            idle_cnt   = '0;
            in_frame   = 1'b0;
            shift_reg  = '0;
            ref_code   = '0;
            armed      = 1'b0;
            btn_hist   = '0;
            pending_decodes.delete();
            fail_count   = 0;
            results_seen = 0;
            frame_events = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BIT_MIN:  win_lo     = cfg_wdata;
                    REG_BIT_MAX:  win_hi     = cfg_wdata;
                    REG_TIMEOUT:  idle_limit = cfg_wdata;
                    REG_VOTE_THR: vote_thr   = cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end
            // result out first: it always belongs to an earlier input transaction
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_decodes.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    fail_count++;
                end else begin
                    want = pending_decodes.pop_front();
                    if (m_data.event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d",
                               want.event_res, m_data.event_res);
                        fail_count++;
                    end
                    if (m_data.code !== want.code) begin
                        $error("code: expected 0x%08h, got 0x%08h", want.code, m_data.code);
                        fail_count++;
                    end
                    if (m_data.learned_code !== want.learned_code) begin
                        $error("learned_code: expected 0x%08h, got 0x%08h",
                               want.learned_code, m_data.learned_code);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pred = decode_step(s_data);
                if (pred.event_res != EV_NONE) frame_events++;
                pending_decodes.push_back(pred);
            end
        end
        decodes_pending = pending_decodes.size();
    end

endmodule

// ===== verif/ir_pulse_width_decoder_learn_match_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the IR pulse-width decoder: clock, reset, stimulus and verdict.
// Depends on irpw_pkg, the decoder top level and irpw_decode_check.
module ir_pulse_width_decoder_learn_match_top_test;
    import irpw_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    int fail_count;
    int decodes_pending;
    int results_seen;
    int frame_events;

    int cur_min;
    int cur_max;
    int cur_to;
    int items_sent;
    int reg_writes;
    int quiet_cycles;
    bit no_gaps;

    logic [63:0] last_pattern;
    int          last_nbits;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ir_pulse_width_decoder_learn_match_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    irpw_decode_check u_decode_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .decodes_pending (decodes_pending),
        .results_seen    (results_seen),
        .frame_events    (frame_events)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL ir_pulse_width_decoder_learn_match_top");
                $finish;
            end
        end
    end

    // result side: random stall before each result transaction
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(7, 0);
            @(negedge aclk);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
        end
    end

    task automatic send_item(cmd_t c, logic b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(7, 0);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data.cmd = c;
        s_data.button_level = b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic frame_tick();
        send_item(CMD_TICK, $urandom_range(7, 0) == 0);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (decodes_pending != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        reg_writes++;
        case (idx)
            REG_BIT_MIN: cur_min = int'(val);
            REG_BIT_MAX: cur_max = int'(val);
            REG_TIMEOUT: cur_to  = int'(val);
            default: ;
        endcase
    endtask

    task automatic set_regs(int lo, int hi, int to, int thr);
        drain();
        write_reg(REG_BIT_MIN, CFG_DATA_W'(lo));
        write_reg(REG_BIT_MAX, CFG_DATA_W'(hi));
        write_reg(REG_TIMEOUT, CFG_DATA_W'(to));
        write_reg(REG_VOTE_THR, CFG_DATA_W'(thr));
    endtask

    // tick count for one pulse, kept below the idle timeout
    function automatic int pulse_ticks(bit one);
        int lim;
        int hi;
        int below;
        int above_lo;
        int above_hi;
        lim = (cur_to == 0) ? 0 : cur_to - 1;
        if (one) begin
            hi = (cur_max < lim) ? cur_max : lim;
            if (cur_min <= hi) return $urandom_range(hi, cur_min);
        end else begin
            below    = (cur_min < lim + 1) ? cur_min : lim + 1;
            above_lo = cur_max + 1;
            above_hi = (cur_max + 8 < lim) ? cur_max + 8 : lim;
            if (below > 0 && (above_lo > above_hi || $urandom_range(1, 0) == 0))
                return $urandom_range(below - 1, 0);
            if (above_lo <= above_hi) return $urandom_range(above_hi, above_lo);
        end
        return $urandom_range((lim < 8) ? lim : 8, 0);
    endfunction

    task automatic send_frame(int nbits, logic [63:0] pattern, bit learn);
        int i;
        if (learn) repeat (VOTE_WINDOW) send_item(CMD_TICK, 1'b1);
        send_item(CMD_EDGE, 1'($urandom_range(1, 0)));
        for (i = 0; i < nbits; i++) begin
            repeat (pulse_ticks(pattern[i])) frame_tick();
            send_item(CMD_EDGE, 1'($urandom_range(1, 0)));
            if (i != nbits - 1) begin
                repeat ($urandom_range((cur_to > 3) ? 3 : ((cur_to == 0) ? 0 : cur_to - 1), 0))
                    frame_tick();
                send_item(CMD_EDGE, 1'($urandom_range(1, 0)));
            end
        end
        repeat (cur_to + $urandom_range(2, 0)) frame_tick();
    endtask

    task automatic run_phase(int budget);
        int start;
        int sel;
        int r;
        start = items_sent;
        while (items_sent - start < budget) begin
            no_gaps = ($urandom_range(3, 0) == 0);
            if ($urandom_range(15, 0) == 0) drain();
            sel = $urandom_range(9, 0);
            if (sel < 2) begin
                repeat ($urandom_range(15, 3))
                    send_item(cmd_t'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            end else begin
                if (sel < 4 || sel > 6) begin
                    r = $urandom_range(19, 0);
                    last_nbits   = (r < 16) ? $urandom_range(10, 1) :
                                   (r < 19) ? $urandom_range(40, 11) : 0;
                    last_pattern = {$urandom, $urandom};
                end
                send_frame(last_nbits, last_pattern, sel < 4);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_BIT_MIN;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        no_gaps    = 1'b0;
        cur_min    = int'(BIT_MIN_RST);
        cur_max    = int'(BIT_MAX_RST);
        cur_to     = int'(TIMEOUT_RST);
        items_sent = 0;
        reg_writes = 0;
        last_pattern = 64'h5;
        last_nbits   = 3;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: learn one short frame
        send_frame(3, 64'h5, 1'b1);

        // directed: all-zero frame, learn, zero timeout
        set_regs(2, 3, 3, 2);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_EDGE, 1'b1);
        repeat (2) send_item(CMD_TICK, 1'b0);
        send_item(CMD_EDGE, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_EDGE, 1'b0);
        send_item(CMD_EDGE, 1'b1);
        repeat (3) send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_EDGE, 1'b0);
        repeat (2) send_item(CMD_TICK, 1'b0);
        send_item(CMD_EDGE, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_EDGE, 1'b0);
        repeat (3) send_item(CMD_TICK, 1'b0);
        drain();
        write_reg(REG_TIMEOUT, 0);
        send_item(CMD_EDGE, 1'b0);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_TICK, 1'b0);

        // random frames over several settings, extremes included
        set_regs(2, 4, 8, 6);
        run_phase(30);
        set_regs(0, 1023, 6, 0);
        run_phase(30);
        set_regs(1023, 0, 5, 10);
        run_phase(25);
        set_regs(1, 3, 1, 15);
        run_phase(25);
        set_regs(3, 6, 12, 1015);
        run_phase(30);
        repeat (2) begin
            cur_min = $urandom_range(8, 0);
            cur_max = cur_min + $urandom_range(6, 0);
            set_regs(cur_min, cur_max, cur_max + int'($urandom_range(10, 2)),
                     int'($urandom_range(10, 0)));
            run_phase(25);
        end

        // edge counter saturation
        set_regs(0, 2, 2, 0);
        repeat (260) send_item(CMD_EDGE, 1'($urandom_range(1, 0)));
        repeat (3) send_item(CMD_TICK, 1'b0);

        drain();
        repeat (20) @(negedge aclk);
        $display("Run covered %0d input transactions and %0d results, %0d with a frame event,",
                 items_sent, results_seen, frame_events);
        $display("across %0d register writes including the range extremes.", reg_writes);
        if (fail_count == 0 && decodes_pending == 0) begin
            $display("PASS ir_pulse_width_decoder_learn_match_top");
        end else begin
            $display("FAIL ir_pulse_width_decoder_learn_match_top");
        end
        $finish;
    end

endmodule
